@@ rtl/hghk_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hghk_pkg
// Shared types, codes and widths of the hand gesture key qualifier.
// ----------------------------------------------------------------------------
package hghk_pkg;

  localparam int LEVEL_BITS_DEF = 16;
  localparam int TIMER_BITS_DEF = 24;

  localparam int KIND_BITS      = 2;
  localparam int SIDE_BITS      = 2;
  localparam int CONF_BITS      = 16;
  localparam int ELAPSED_BITS   = 20;
  localparam int TIMEOUT_BITS   = 24;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 24;
  localparam int KEY_BITS       = 2;
  localparam int KEY_COUNT      = 4;
  localparam int HAND_COUNT     = 2;
  localparam int OUT_TDATA_BITS = 8;
  localparam int QUEUE_DEPTH    = 2;
  localparam int OP_BITS        = 2;

  localparam logic [KIND_BITS-1:0] KIND_FRAME  = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_REPORT = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_TICK   = 2'd2;

  localparam logic [SIDE_BITS-1:0] SIDE_LEFT  = 2'd0;
  localparam logic [SIDE_BITS-1:0] SIDE_RIGHT = 2'd1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_GRAB_PRESS    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GRAB_RELEASE  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PINCH_PRESS   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PINCH_RELEASE = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STALE_TIMEOUT = 3'd4;

  localparam int PRESS_LEVEL_RST   = 52429;
  localparam int RELEASE_LEVEL_RST = 32768;
  localparam int TIMEOUT_RST       = 200000;

  typedef enum logic [OP_BITS-1:0] {
    OP_CLEAR,
    OP_REPORT,
    OP_TICK
  } op_t;

  typedef enum logic {
    BK_RUN,
    BK_EVAL
  } back_state_t;

  // side, confidence, grab, pinch, elapsed
  function automatic int in_data_bits(int lb);
    return SIDE_BITS + CONF_BITS + 2 * lb + ELAPSED_BITS;
  endfunction

  function automatic int in_tdata_bits(int lb);
    return ((in_data_bits(lb) + 7) >> 3) << 3;
  endfunction

  // op, side, grab, pinch, elapsed
  function automatic int entry_bits(int lb);
    return OP_BITS + 1 + 2 * lb + ELAPSED_BITS;
  endfunction

endpackage

@@ rtl/hghk_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hghk_cfg
// Threshold and timeout registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module hghk_cfg import hghk_pkg::*; #(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output logic [LEVEL_BITS-1:0]     grab_press,
  output logic [LEVEL_BITS-1:0]     grab_release,
  output logic [LEVEL_BITS-1:0]     pinch_press,
  output logic [LEVEL_BITS-1:0]     pinch_release,
  output logic [TIMEOUT_BITS-1:0]   stale_timeout
);

  logic [LEVEL_BITS-1:0]   grab_press_r;
  logic [LEVEL_BITS-1:0]   grab_release_r;
  logic [LEVEL_BITS-1:0]   pinch_press_r;
  logic [LEVEL_BITS-1:0]   pinch_release_r;
  logic [TIMEOUT_BITS-1:0] stale_timeout_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grab_press_r    <= LEVEL_BITS'(PRESS_LEVEL_RST);
      grab_release_r  <= LEVEL_BITS'(RELEASE_LEVEL_RST);
      pinch_press_r   <= LEVEL_BITS'(PRESS_LEVEL_RST);
      pinch_release_r <= LEVEL_BITS'(RELEASE_LEVEL_RST);
      stale_timeout_r <= TIMEOUT_BITS'(TIMEOUT_RST);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GRAB_PRESS:    grab_press_r    <= cfg_data[LEVEL_BITS-1:0];
        REG_GRAB_RELEASE:  grab_release_r  <= cfg_data[LEVEL_BITS-1:0];
        REG_PINCH_PRESS:   pinch_press_r   <= cfg_data[LEVEL_BITS-1:0];
        REG_PINCH_RELEASE: pinch_release_r <= cfg_data[LEVEL_BITS-1:0];
        REG_STALE_TIMEOUT: stale_timeout_r <= cfg_data[TIMEOUT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign grab_press    = grab_press_r;
  assign grab_release  = grab_release_r;
  assign pinch_press   = pinch_press_r;
  assign pinch_release = pinch_release_r;
  assign stale_timeout = stale_timeout_r;

endmodule

@@ rtl/hghk_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hghk_front
// Accepts input items, drops those with no effect and packs the rest as ops.
// ----------------------------------------------------------------------------
module hghk_front import hghk_pkg::*; #(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF,
  parameter int IN_TDATA_W = in_tdata_bits(LEVEL_BITS_DEF),
  parameter int ENTRY_W    = entry_bits(LEVEL_BITS_DEF)
) (
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [KIND_BITS-1:0]  in_tuser,
  input  logic                  q_ready,
  output logic                  q_push,
  output logic [ENTRY_W-1:0]    q_wdata
);

  localparam int CONF_LO  = SIDE_BITS;
  localparam int GRAB_LO  = CONF_LO + CONF_BITS;
  localparam int PINCH_LO = GRAB_LO + LEVEL_BITS;
  localparam int ELAP_LO  = PINCH_LO + LEVEL_BITS;

  logic [SIDE_BITS-1:0]    side;
  logic [CONF_BITS-1:0]    conf;
  logic [LEVEL_BITS-1:0]   grab;
  logic [LEVEL_BITS-1:0]   pinch;
  logic [ELAPSED_BITS-1:0] elapsed;
  op_t                     op;
  logic                    keep;

  assign side    = in_tdata[SIDE_BITS-1:0];
  assign conf    = in_tdata[CONF_LO +: CONF_BITS];
  assign grab    = in_tdata[GRAB_LO +: LEVEL_BITS];
  assign pinch   = in_tdata[PINCH_LO +: LEVEL_BITS];
  assign elapsed = in_tdata[ELAP_LO +: ELAPSED_BITS];

  always_comb begin
    op   = OP_CLEAR;
    keep = 1'b0;
    case (in_tuser)
      KIND_FRAME: begin
        op   = OP_CLEAR;
        keep = 1'b1;
      end
      KIND_REPORT: begin
        op   = OP_REPORT;
        keep = (conf != '0) && ((side == SIDE_LEFT) || (side == SIDE_RIGHT));
      end
      KIND_TICK: begin
        op   = OP_TICK;
        keep = 1'b1;
      end
      default: ;
    endcase
  end

  assign in_tready = q_ready;
  assign q_push    = in_tvalid && q_ready && keep;
  assign q_wdata   = {elapsed, pinch, grab, side[0], op};

endmodule

@@ rtl/hghk_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hghk_queue
// Short op queue between the front and back parts.
// ----------------------------------------------------------------------------
module hghk_queue import hghk_pkg::*; #(
  parameter int WIDTH = entry_bits(LEVEL_BITS_DEF),
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             push_ready,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign rdata      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ rtl/hghk_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hghk_back
// Hand state, timers, hysteresis and the event output register.
// ----------------------------------------------------------------------------
module hghk_back import hghk_pkg::*; #(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF,
  parameter int TIMER_BITS = TIMER_BITS_DEF,
  parameter int ENTRY_W    = entry_bits(LEVEL_BITS_DEF)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  logic [ENTRY_W-1:0]        q_rdata,
  output logic                      q_pop,
  input  logic [LEVEL_BITS-1:0]     grab_press,
  input  logic [LEVEL_BITS-1:0]     grab_release,
  input  logic [LEVEL_BITS-1:0]     pinch_press,
  input  logic [LEVEL_BITS-1:0]     pinch_release,
  input  logic [TIMEOUT_BITS-1:0]   stale_timeout,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_TDATA_BITS-1:0] out_tdata,
  output logic                      out_tlast
);

  localparam int SUM_W = ((TIMER_BITS > ELAPSED_BITS) ? TIMER_BITS : ELAPSED_BITS) + 1;
  localparam int CMP_W = (TIMER_BITS > TIMEOUT_BITS) ? TIMER_BITS : TIMEOUT_BITS;
  localparam int GRAB_LO  = OP_BITS + 1;
  localparam int PINCH_LO = GRAB_LO + LEVEL_BITS;
  localparam int ELAP_LO  = PINCH_LO + LEVEL_BITS;

  op_t                     e_op;
  logic                    e_side;
  logic [LEVEL_BITS-1:0]   e_grab;
  logic [LEVEL_BITS-1:0]   e_pinch;
  logic [ELAPSED_BITS-1:0] e_elapsed;

  back_state_t           state_r, state_nxt;
  logic [LEVEL_BITS-1:0] held_grab_r  [HAND_COUNT];
  logic [LEVEL_BITS-1:0] held_grab_nxt  [HAND_COUNT];
  logic [LEVEL_BITS-1:0] held_pinch_r [HAND_COUNT];
  logic [LEVEL_BITS-1:0] held_pinch_nxt [HAND_COUNT];
  logic [TIMER_BITS-1:0] unseen_r     [HAND_COUNT];
  logic [TIMER_BITS-1:0] unseen_nxt     [HAND_COUNT];
  logic [HAND_COUNT-1:0] grab_down_r, grab_down_nxt;
  logic [HAND_COUNT-1:0] pinch_down_r, pinch_down_nxt;
  logic [KEY_COUNT-1:0]  pend_r, pend_nxt;
  logic [KEY_COUNT-1:0]  press_r, press_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [KEY_BITS-1:0]   out_key_r, out_key_nxt;
  logic                  out_pressed_r, out_pressed_nxt;
  logic                  out_last_r, out_last_nxt;

  assign e_op      = op_t'(q_rdata[OP_BITS-1:0]);
  assign e_side    = q_rdata[OP_BITS];
  assign e_grab    = q_rdata[GRAB_LO +: LEVEL_BITS];
  assign e_pinch   = q_rdata[PINCH_LO +: LEVEL_BITS];
  assign e_elapsed = q_rdata[ELAP_LO +: ELAPSED_BITS];

  always_comb begin
    logic [SUM_W-1:0]      sum;
    logic [TIMER_BITS-1:0] t;
    logic [KEY_BITS-1:0]   sel;
    logic [KEY_COUNT-1:0]  rest;
    logic                  slot_free;

    state_nxt       = state_r;
    held_grab_nxt   = held_grab_r;
    held_pinch_nxt  = held_pinch_r;
    unseen_nxt      = unseen_r;
    grab_down_nxt   = grab_down_r;
    pinch_down_nxt  = pinch_down_r;
    pend_nxt        = pend_r;
    press_nxt       = press_r;
    out_valid_nxt   = out_valid_r;
    out_key_nxt     = out_key_r;
    out_pressed_nxt = out_pressed_r;
    out_last_nxt    = out_last_r;
    q_pop           = 1'b0;
    sum             = '0;
    t               = '0;
    sel             = '0;
    rest            = '0;
    slot_free       = !out_valid_r || out_tready;

    // issue the lowest pending event
    for (int k = KEY_COUNT - 1; k >= 0; k--) begin
      if (pend_r[k]) begin
        sel = KEY_BITS'(k);
      end
    end
    rest = pend_r & ~(KEY_COUNT'(1) << sel);
    if (pend_r != '0 && slot_free) begin
      out_valid_nxt   = 1'b1;
      out_key_nxt     = sel;
      out_pressed_nxt = press_r[sel];
      out_last_nxt    = (rest == '0);
      pend_nxt        = rest;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      BK_RUN: begin
        if (q_valid && (e_op != OP_TICK || pend_r == '0)) begin
          q_pop = 1'b1;
          case (e_op)
            OP_CLEAR: begin
              for (int h = 0; h < HAND_COUNT; h++) begin
                held_grab_nxt[h]  = '0;
                held_pinch_nxt[h] = '0;
              end
            end
            OP_REPORT: begin
              if (e_grab > held_grab_r[e_side]) begin
                held_grab_nxt[e_side] = e_grab;
              end
              if (e_pinch > held_pinch_r[e_side]) begin
                held_pinch_nxt[e_side] = e_pinch;
              end
              unseen_nxt[e_side] = '0;
            end
            OP_TICK: begin
              for (int h = 0; h < HAND_COUNT; h++) begin
                sum = SUM_W'(unseen_r[h]) + SUM_W'(e_elapsed);
                t   = (sum[SUM_W-1:TIMER_BITS] != '0) ? '1 : sum[TIMER_BITS-1:0];
                unseen_nxt[h] = t;
                if (CMP_W'(t) > CMP_W'(stale_timeout)) begin
                  held_grab_nxt[h]  = '0;
                  held_pinch_nxt[h] = '0;
                end
              end
              state_nxt = BK_EVAL;
            end
            default: ;
          endcase
        end
      end
      BK_EVAL: begin
        for (int h = 0; h < HAND_COUNT; h++) begin
          press_nxt[2*h]     = !grab_down_r[h];
          press_nxt[2*h + 1] = !pinch_down_r[h];
          pend_nxt[2*h] = grab_down_r[h] ? (held_grab_r[h] <= grab_release)
                                         : (held_grab_r[h] >= grab_press);
          pend_nxt[2*h + 1] = pinch_down_r[h] ? (held_pinch_r[h] <= pinch_release)
                                              : (held_pinch_r[h] >= pinch_press);
          grab_down_nxt[h]  = grab_down_r[h] ^ pend_nxt[2*h];
          pinch_down_nxt[h] = pinch_down_r[h] ^ pend_nxt[2*h + 1];
        end
        state_nxt = BK_RUN;
      end
      default: state_nxt = BK_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_RUN;
      grab_down_r  <= '0;
      pinch_down_r <= '0;
      pend_r       <= '0;
      out_valid_r  <= 1'b0;
      for (int h = 0; h < HAND_COUNT; h++) begin
        held_grab_r[h]  <= '0;
        held_pinch_r[h] <= '0;
        unseen_r[h]     <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      grab_down_r  <= grab_down_nxt;
      pinch_down_r <= pinch_down_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
      held_grab_r  <= held_grab_nxt;
      held_pinch_r <= held_pinch_nxt;
      unseen_r     <= unseen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    press_r       <= press_nxt;
    out_key_r     <= out_key_nxt;
    out_pressed_r <= out_pressed_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_BITS'({out_pressed_r, out_key_r});
  assign out_tlast  = out_last_r;

endmodule

@@ rtl/hand_gesture_hysteresis_keys.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hand_gesture_hysteresis_keys
// Grab and pinch key qualifier for two tracked hands with stale timeout.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  in_*     in   tuser: kind; tdata: hand_side, confidence, grab, pinch, elapsed
//  out_*    out  tdata: key_id, pressed; tlast: last event of a tick
//  cfg_*    in   cfg_index: register 0..4; cfg_data: value
//
//  Frames and reports are popped and applied in BK_RUN; an item can enter every
//  cycle while the two-entry op queue has room.
//  A tick updates the timers in BK_RUN and evaluates hysteresis in BK_EVAL;
//  its 0..4 events then move one per cycle into the output register while it
//  is not stalled, and the next tick may start once all of them are issued.
//  Synchronous active-low reset clears hand state and loads default levels.
//  Output stalls hold the event register; a blocked tick then fills the queue.
// ----------------------------------------------------------------------------
module hand_gesture_hysteresis_keys import hghk_pkg::*; #(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF,
  parameter int TIMER_BITS = TIMER_BITS_DEF,
  localparam int IN_TDATA_W = in_tdata_bits(LEVEL_BITS)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // hand_side, confidence, grab_level, pinch_level, elapsed_us, zero pad
  input  logic [IN_TDATA_W-1:0]     in_tdata,
  // kind
  input  logic [KIND_BITS-1:0]      in_tuser,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // key_id, pressed, zero pad
  output logic [OUT_TDATA_BITS-1:0] out_tdata,
  output logic                      out_tlast,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int ENTRY_W = entry_bits(LEVEL_BITS);

  logic                    q_push;
  logic                    q_ready;
  logic [ENTRY_W-1:0]      q_wdata;
  logic                    q_pop;
  logic                    q_valid;
  logic [ENTRY_W-1:0]      q_rdata;
  logic [LEVEL_BITS-1:0]   grab_press;
  logic [LEVEL_BITS-1:0]   grab_release;
  logic [LEVEL_BITS-1:0]   pinch_press;
  logic [LEVEL_BITS-1:0]   pinch_release;
  logic [TIMEOUT_BITS-1:0] stale_timeout;

  hghk_cfg #(
    .LEVEL_BITS(LEVEL_BITS)
  ) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .grab_press   (grab_press),
    .grab_release (grab_release),
    .pinch_press  (pinch_press),
    .pinch_release(pinch_release),
    .stale_timeout(stale_timeout)
  );

  hghk_front #(
    .LEVEL_BITS(LEVEL_BITS),
    .IN_TDATA_W(IN_TDATA_W),
    .ENTRY_W   (ENTRY_W)
  ) u_front (
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  hghk_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_ready(q_ready),
    .wdata     (q_wdata),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .rdata     (q_rdata)
  );

  hghk_back #(
    .LEVEL_BITS(LEVEL_BITS),
    .TIMER_BITS(TIMER_BITS),
    .ENTRY_W   (ENTRY_W)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_rdata      (q_rdata),
    .q_pop        (q_pop),
    .grab_press   (grab_press),
    .grab_release (grab_release),
    .pinch_press  (pinch_press),
    .pinch_release(pinch_release),
    .stale_timeout(stale_timeout),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast)
  );

endmodule

@@ rtl/hghk_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hghk_checker
// Port-level checks on the event stream of the key qualifier.
// ----------------------------------------------------------------------------
module hghk_checker import hghk_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [OUT_TDATA_BITS-1:0] out_tdata,
  input logic                      out_tlast
);

  logic                 out_acc;
  logic [KEY_COUNT-1:0] key_down_r;
  logic [1:0]           cnt_r;

  assign out_acc = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_down_r <= '0;
      cnt_r      <= '0;
    end else if (out_acc) begin
      key_down_r[out_tdata[KEY_BITS-1:0]] <= out_tdata[KEY_BITS];
      cnt_r <= out_tlast ? 2'd0 : cnt_r + 2'd1;
    end
  end

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("event valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled event changed");

  a_alternate: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> out_tdata[KEY_BITS] != key_down_r[out_tdata[KEY_BITS-1:0]])
    else $error("key event repeats its previous direction");

  a_tick_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && cnt_r == 2'd3 |-> out_tlast)
    else $error("more than four events in one tick");

endmodule

bind hand_gesture_hysteresis_keys hghk_checker u_hghk_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast)
);
